// ===== rtl/bsfr_pkg.sv =====
package bsfr_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 9;
   localparam int KIND_W  = 2;
   localparam int ADDR_W  = 2;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'd126;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'd127;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
   localparam logic [BYTE_W-1:0] MASK_RESET   = 8'd32;

   typedef enum logic [ADDR_W-1:0] {
      REG_START  = 2'd0,
      REG_END    = 2'd1,
      REG_ESCAPE = 2'd2,
      REG_MASK   = 2'd3
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      EV_DATA    = 2'd0,
      EV_DONE    = 2'd1,
      EV_ABORT   = 2'd2,
      EV_REFUSED = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_MSG  = 3'b010,
      MODE_ESC  = 3'b100
   } rx_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [BYTE_W-1:0] escape_code;
      logic [BYTE_W-1:0] stuff_mask;
   } codes_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [INDEX_W-1:0] byte_index;
      event_kind_type     event_kind;
      logic [LEN_W-1:0]   frame_length;
      logic               overflowed;
   } result_type;

endpackage

// ===== rtl/bsfr_csr.sv =====
module bsfr_csr
   import bsfr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [ADDR_W-1:0]          csr_addr,
   input  logic [BYTE_W-1:0]          csr_wdata,
   output codes_type                  codes
);

   codes_type codes_ff;
   codes_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_START:  codes_in.start_code  = csr_wdata;
            REG_END:    codes_in.end_code    = csr_wdata;
            REG_ESCAPE: codes_in.escape_code = csr_wdata;
            REG_MASK:   codes_in.stuff_mask  = csr_wdata;
            default:    codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.start_code  <= START_RESET;
         codes_ff.end_code    <= END_RESET;
         codes_ff.escape_code <= ESCAPE_RESET;
         codes_ff.stuff_mask  <= MASK_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign codes = codes_ff;

endmodule

// ===== rtl/bsfr_core.sv =====
module bsfr_core
   import bsfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  codes_type         codes,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_byte,
   input  logic              req_free,
   input  logic              out_ready,
   output logic              push,
   output result_type        result
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_free_ff;

   rx_mode_type       mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;

   logic              res_valid;
   logic              process;
   logic              hit_start;
   logic [BYTE_W-1:0] store_val;
   logic              do_store;

   always_comb begin
      hit_start = (in_byte_ff == codes.start_code);
      mode_in   = mode_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      do_store  = 1'b0;
      store_val = in_byte_ff;
      result    = '{out_byte: '0, byte_index: '0, event_kind: EV_DATA,
                    frame_length: '0, overflowed: 1'b0};

      if (hit_start) begin
         if (mode_ff != MODE_IDLE) begin
            // start inside a frame aborts it and reuses the buffer
            res_valid           = 1'b1;
            result.event_kind   = EV_ABORT;
            result.frame_length = LEN_W'(count_ff);
            result.overflowed   = ovf_ff;
            mode_in  = MODE_MSG;
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (in_free_ff) begin
            mode_in  = MODE_MSG;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            res_valid         = 1'b1;
            result.event_kind = EV_REFUSED;
            mode_in           = MODE_IDLE;
         end
      end else begin
         case (mode_ff)
            MODE_MSG: begin
               if (in_byte_ff == codes.escape_code) begin
                  mode_in = MODE_ESC;
               end else if (in_byte_ff == codes.end_code) begin
                  res_valid           = 1'b1;
                  result.event_kind   = EV_DONE;
                  result.frame_length = LEN_W'(count_ff);
                  result.overflowed   = ovf_ff;
                  mode_in             = MODE_IDLE;
               end else begin
                  do_store = 1'b1;
               end
            end
            MODE_ESC: begin
               mode_in   = MODE_MSG;
               do_store  = 1'b1;
               store_val = in_byte_ff ^ codes.stuff_mask;
            end
            default: mode_in = MODE_IDLE;
         endcase
      end

      if (do_store) begin
         if (count_ff >= CNT_W'(MAX_FRAME_BYTES)) begin
            ovf_in = 1'b1;
         end else begin
            res_valid         = 1'b1;
            result.out_byte   = store_val;
            result.byte_index = INDEX_W'(count_ff);
            result.event_kind = EV_DATA;
            count_in          = count_ff + CNT_W'(1);
         end
      end
   end

   // items with no result never wait on the result register
   assign process     = in_valid_ff && (!res_valid || out_ready);
   assign push        = process && res_valid;
   assign req_tready  = !in_valid_ff || process;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (process) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_byte;
         in_free_ff <= req_free;
      end
   end

endmodule

// ===== rtl/bsfr_out.sv =====
module bsfr_out
   import bsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  result_type  result,
   output logic        out_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, res_ff.overflowed, res_ff.frame_length,
                        res_ff.byte_index, res_ff.out_byte};
   assign rsp_tuser  = res_ff.event_kind;

endmodule

// ===== rtl/byte_stuffed_frame_receiver.sv =====
// channel   ports                  contents
// request   req_tvalid/tready      tdata: rx_byte; tuser: buffer_free
// response  rsp_tvalid/tready      tdata: out_byte, byte_index, frame_length,
//                                  overflowed; tuser: event_kind
// config    csr_we/addr/wdata      start, end, escape codes and stuff mask
//
// one request per cycle unless a response stalls; a taken request loads the
// input register, and its response then moves into the result register
// the frame state machine updates once per request, which sets the rate
// synchronous active-high reset clears the frame state and restores the codes
// a stalled response holds the result register; requests with no response
// still drain while the response side stalls
module byte_stuffed_frame_receiver
   import bsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] buffer_free
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [15:8] byte_index,
                                    // [24:16] frame_length, [25] overflowed
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   codes_type  codes;
   result_type result;
   logic       push;
   logic       out_ready;

   bsfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .codes     (codes)
   );

   bsfr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .codes      (codes),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_free   (req_tuser),
      .out_ready  (out_ready),
      .push       (push),
      .result     (result)
   );

   bsfr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import bsfr_pkg::*;
();

   class frame_scoreboard;
      codes_type   codes;
      rx_mode_type mode;
      logic [8:0]  stored;
      logic        dropped;
      result_type  pending[$];
      int errors;
      int data_bytes;
      int frames_done;
      int frames_aborted;
      int frames_refused;
      int frames_overflowed;

      function new();
         codes.start_code  = START_RESET;
         codes.end_code    = END_RESET;
         codes.escape_code = ESCAPE_RESET;
         codes.stuff_mask  = MASK_RESET;
         mode    = MODE_IDLE;
         stored  = '0;
         dropped = 1'b0;
      endfunction

      function void write_code(reg_index_type idx, logic [7:0] value);
         case (idx)
            REG_START:  codes.start_code  = value;
            REG_END:    codes.end_code    = value;
            REG_ESCAPE: codes.escape_code = value;
            REG_MASK:   codes.stuff_mask  = value;
            default: ;
         endcase
      endfunction

      // payload byte lands in the buffer unless the frame is already full
      function void store_payload(logic [7:0] value);
         result_type r;
         r = '0;
         if (stored >= MAX_FRAME_BYTES) begin
            dropped = 1'b1;
         end else begin
            r.out_byte   = value;
            r.byte_index = stored[7:0];
            r.event_kind = EV_DATA;
            pending.push_back(r);
            stored = stored + 1'b1;
         end
      endfunction

      function void close_frame(event_kind_type kind);
         result_type r;
         r = '0;
         r.event_kind   = kind;
         r.frame_length = stored;
         r.overflowed   = dropped;
         pending.push_back(r);
      endfunction

      function void note_request(logic [7:0] rx, logic free);
         result_type r;
         r = '0;
         if (rx == codes.start_code) begin
            // start code beats every other decode, even right after an escape
            if (mode != MODE_IDLE) begin
               close_frame(EV_ABORT);
               mode    = MODE_MSG;
               stored  = '0;
               dropped = 1'b0;
            end else if (free) begin
               mode    = MODE_MSG;
               stored  = '0;
               dropped = 1'b0;
            end else begin
               r.event_kind = EV_REFUSED;
               pending.push_back(r);
            end
         end else if (mode == MODE_MSG) begin
            if (rx == codes.escape_code) begin
               mode = MODE_ESC;
            end else if (rx == codes.end_code) begin
               close_frame(EV_DONE);
               mode = MODE_IDLE;
            end else begin
               store_payload(rx);
            end
         end else if (mode == MODE_ESC) begin
            mode = MODE_MSG;
            store_payload(rx ^ codes.stuff_mask);
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("error at %0t ns: %s", $time, what);
      endtask

      task check_result(logic [31:0] data, logic [1:0] kind);
         result_type want;
         if (pending.size() == 0) begin
            report($sformatf("response with nothing pending: kind %0d data %h", kind, data));
            return;
         end
         want = pending.pop_front();
         if (kind !== want.event_kind)
            report($sformatf("event_kind %0d, want %0d", kind, want.event_kind));
         if (data[7:0] !== want.out_byte)
            report($sformatf("out_byte %h, want %h", data[7:0], want.out_byte));
         if (data[15:8] !== want.byte_index)
            report($sformatf("byte_index %0d, want %0d", data[15:8], want.byte_index));
         if (data[24:16] !== want.frame_length)
            report($sformatf("frame_length %0d, want %0d", data[24:16], want.frame_length));
         if (data[25] !== want.overflowed)
            report($sformatf("overflowed %b, want %b", data[25], want.overflowed));
         case (want.event_kind)
            EV_DATA:    data_bytes++;
            EV_DONE:    frames_done++;
            EV_ABORT:   frames_aborted++;
            EV_REFUSED: frames_refused++;
            default: ;
         endcase
         if (want.overflowed) frames_overflowed++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] rx_byte
   logic        req_tuser = 1'b0;  // [0] buffer_free
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] out_byte, [15:8] byte_index,
                                   // [24:16] frame_length, [25] overflowed
   logic [1:0]  rsp_tuser;         // [1:0] event_kind
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   frame_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  stall_requested = 1'b0;
   int  total_requests = 0;
   int  frame_items = 0;

   byte_stuffed_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout");
      $display("byte_stuffed_frame_receiver: mismatch");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off on demand
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_result(rsp_tdata, rsp_tuser);
         if (stall_requested) begin
            stall_requested = 1'b0;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx, input logic free);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= free;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(rx, free);
      total_requests++;
   endtask

   // quiet the request side and let the pipeline drain, including requests
   // that produce no response
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_code(idx, value);
   endtask

   task automatic load_codes(input codes_type c);
      settle();
      write_register(REG_START, c.start_code);
      write_register(REG_END, c.end_code);
      write_register(REG_ESCAPE, c.escape_code);
      write_register(REG_MASK, c.stuff_mask);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_frame(input int body_len);
      int i;
      int pick;
      logic [7:0] follower;
      // line noise while idle, mostly dropped
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      send_byte(board.codes.start_code, $urandom_range(9) != 0);
      frame_items++;
      for (i = 0; i < body_len; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_byte(board.codes.escape_code, 1'($urandom_range(1)));
            case ($urandom_range(9))
               0: follower = board.codes.end_code;
               1: follower = board.codes.escape_code;
               2: follower = board.codes.start_code;
               default: follower = 8'($urandom_range(255));
            endcase
            send_byte(follower, 1'($urandom_range(1)));
            frame_items += 2;
         end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            frame_items++;
         end
      end
      pick = $urandom_range(9);
      if (pick < 8) begin
         send_byte(board.codes.end_code, 1'($urandom_range(1)));
         frame_items++;
      end else if (pick == 8) begin
         send_byte(board.codes.start_code, 1'($urandom_range(1)));
         frame_items++;
      end
   endtask

   task automatic run_random(input int quota);
      int goal;
      int len;
      goal = frame_items + quota;
      while (frame_items < goal) begin
         len = ($urandom_range(39) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 24);
         send_random_frame(len);
      end
   endtask

   // payload that avoids the reset codes, long enough to run past capacity
   task automatic send_long_body(input int count);
      int i;
      for (i = 0; i < count; i++) send_byte(8'(i % 8'h60), 1'b1);
   endtask

   initial begin
      codes_type c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset codes: start 7e, end 7f, escape 7d, mask 20
      send_idle_pct = 22;
      recv_idle_pct = 58;
      send_byte(8'h00, 1'b1);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h7e, 1'b0);      // refused, no buffer
      send_byte(8'h7e, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h7d, 1'b1);
      send_byte(8'h7f, 1'b1);      // stuffed end code
      send_byte(8'h7d, 1'b0);
      send_byte(8'h7d, 1'b1);      // stuffed escape code
      send_byte(8'h7d, 1'b1);
      send_byte(8'h7e, 1'b0);      // start right after escape aborts
      send_byte(8'ha5, 1'b1);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h7d, 1'b1);      // escape while idle
      send_byte(8'h7e, 1'b1);
      send_byte(8'h7f, 1'b0);      // empty frame
      send_byte(8'h7e, 1'b1);
      send_byte(8'h7e, 1'b0);      // abort ignores buffer_free
      send_long_body(258);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h7e, 1'b1);
      send_long_body(260);
      send_byte(8'h7e, 1'b1);      // abort an overflowed frame
      send_byte(8'h7f, 1'b1);
      run_random(160);

      // start and escape both zero, start wins
      c.start_code  = 8'h00;
      c.end_code    = 8'hff;
      c.escape_code = 8'h00;
      c.stuff_mask  = 8'hff;
      load_codes(c);
      send_idle_pct = 58;
      recv_idle_pct = 22;
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      run_random(160);

      // end and escape equal, escape wins
      c.start_code  = 8'hff;
      c.end_code    = 8'h55;
      c.escape_code = 8'h55;
      c.stuff_mask  = 8'h00;
      load_codes(c);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_byte(8'hff, 1'b1);
      send_byte(8'h55, 1'b1);
      send_byte(8'h55, 1'b1);
      send_byte(8'h12, 1'b1);
      send_byte(8'hff, 1'b1);
      stall_requested = 1'b1;
      send_random_frame(60);
      run_random(160);

      c.start_code  = 8'($urandom_range(255));
      c.end_code    = 8'($urandom_range(255));
      c.escape_code = 8'($urandom_range(255));
      c.stuff_mask  = 8'($urandom_range(255));
      load_codes(c);
      send_idle_pct = 22;
      recv_idle_pct = 58;
      run_random(160);

      settle();
      $display("%0d requests sent: %0d payload bytes, %0d frames complete, %0d aborted, %0d refused",
               total_requests, board.data_bytes, board.frames_done, board.frames_aborted,
               board.frames_refused);
      $display("%0d overflowed frames, four code settings, three idle patterns, one long stall",
               board.frames_overflowed);
      if (board.errors == 0) begin
         $display("byte_stuffed_frame_receiver: match");
      end else begin
         $display("byte_stuffed_frame_receiver: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bsfr_pkg.sv
rtl/bsfr_csr.sv
rtl/bsfr_core.sv
rtl/bsfr_out.sv
rtl/byte_stuffed_frame_receiver.sv
bench/testbench.sv
